// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define TDPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication: when ante holds, cons must hold in the same cycle.
`define TDPT_ASSERT_IMP(lbl, ante, cons, msg) \
  `TDPT_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ----- rtl/tdpt_pkg.sv -----
// ---------------------------------------------------------------------------
// tdpt_pkg
// Shared constants, controller states and command/status types for the
// trial-division prime tester.
// ---------------------------------------------------------------------------
package tdpt_pkg;

  localparam int WIDTH   = 16;            // tested bits of the value
  localparam int VALUE_W = 16;            // port width of the value field
  localparam int SQ_W    = WIDTH + 2;     // running divisor square
  localparam int CNT_W   = $clog2(WIDTH); // remainder bit counter

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_TEST,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;       // capture value, divisor 2, square 4
    logic div_start;  // clear remainder, load dividend bits
    logic div_step;   // one restoring remainder step
    logic advance;    // next divisor, update square
    logic load_out;   // move verdict into output register
    logic prime;      // verdict to load
  } cmd_t;

  typedef struct packed {
    logic lt2;        // value below two
    logic sq_gt;      // divisor squared exceeds value
    logic rem_zero;   // remainder is zero
    logic cnt_last;   // last remainder step this cycle
  } sts_t;

endpackage

// ----- rtl/tdpt_dp.sv -----
// ---------------------------------------------------------------------------
// tdpt_dp
// Datapath: held value, trial divisor with running square, bit-serial
// restoring remainder unit and the output register.
// ---------------------------------------------------------------------------
module tdpt_dp import tdpt_pkg::*; (
  input  logic               clk,
  input  logic [VALUE_W-1:0] in_value,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic               out_is_prime
);

  logic [WIDTH-1:0] v_r,   v_nxt;
  logic [WIDTH-1:0] d_r,   d_nxt;
  logic [SQ_W-1:0]  sq_r,  sq_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] q_r,   q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             res_r, res_nxt;

  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  assign shifted = {rem_r, q_r[WIDTH-1]};
  assign diff    = shifted - {1'b0, d_r};

  always_comb begin
    v_nxt   = v_r;
    d_nxt   = d_r;
    sq_nxt  = sq_r;
    rem_nxt = rem_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    res_nxt = res_r;
    if (cmd.load) begin
      v_nxt  = WIDTH'(in_value);
      d_nxt  = WIDTH'(2);
      sq_nxt = SQ_W'(4);
    end
    if (cmd.div_start) begin
      rem_nxt = '0;
      q_nxt   = v_r;
      cnt_nxt = '0;
    end
    if (cmd.div_step) begin
      rem_nxt = diff[WIDTH] ? shifted[WIDTH-1:0] : diff[WIDTH-1:0];
      q_nxt   = {q_r[WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    if (cmd.advance) begin
      // (d+1)^2 = d^2 + 2d + 1
      sq_nxt = sq_r + {1'b0, d_r, 1'b1};
      d_nxt  = d_r + WIDTH'(1);
    end
    if (cmd.load_out) begin
      res_nxt = cmd.prime;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    d_r   <= d_nxt;
    sq_r  <= sq_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
  end

  assign sts.lt2      = (v_r[WIDTH-1:1] == '0);
  assign sts.sq_gt    = (sq_r > SQ_W'(v_r));
  assign sts.rem_zero = (rem_r == '0);
  assign sts.cnt_last = (cnt_r == CNT_W'(WIDTH - 1));

  assign out_is_prime = res_r;

endmodule

// ----- rtl/tdpt_ctrl.sv -----
// ---------------------------------------------------------------------------
// tdpt_ctrl
// Controller: sequences divisor checks and remainder steps, owns the
// handshakes of both channels.
// ---------------------------------------------------------------------------
module tdpt_ctrl import tdpt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   prime_r, prime_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = (sts.lt2 || sts.sq_gt) ? ST_DONE : ST_DIV;
      ST_DIV:   if (sts.cnt_last) state_nxt = ST_TEST;
      ST_TEST:  state_nxt = sts.rem_zero ? ST_DONE : ST_CHECK;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    prime_nxt = prime_r;
    if (state_r == ST_CHECK) begin
      if (sts.lt2) begin
        prime_nxt = 1'b0;
      end else if (sts.sq_gt) begin
        prime_nxt = 1'b1;
      end
    end
    if (state_r == ST_TEST && sts.rem_zero) begin
      prime_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (state_r == ST_DONE && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.prime     = prime_r;
    in_ready      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CHECK: cmd.div_start = !sts.lt2 && !sts.sq_gt;
      ST_DIV:   cmd.div_step  = 1'b1;
      ST_TEST:  cmd.advance   = !sts.rem_zero;
      ST_DONE:  cmd.load_out  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      prime_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      prime_r     <= prime_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/trial_division_prime_test.sv -----
// ---------------------------------------------------------------------------
// trial_division_prime_test
// Reports whether an unsigned value is prime by trial division.
// ---------------------------------------------------------------------------
// One request is tested at a time. Divisors run upward from 2 until one
// divides the value or the divisor squared exceeds it; values below two are
// not prime. Each divisor takes a bound check, WIDTH steps of the bit-serial
// remainder unit and a zero test, so the time for a request grows with the
// number of divisors tried, least for even or small values and most for the
// largest 16-bit primes. The result sits in an output register; a new
// request is taken as soon as the previous verdict has been handed to that
// register.
`include "assert_macros.svh"

module trial_division_prime_test import tdpt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_is_prime
);

  cmd_t cmd;
  sts_t sts;

  tdpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tdpt_dp u_dp (
    .clk          (clk),
    .in_value     (in_value),
    .cmd          (cmd),
    .sts          (sts),
    .out_is_prime (out_is_prime)
  );

  `TDPT_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "ready after accept")
  `TDPT_ASSERT(a_cmd_exclusive, $onehot0({cmd.load, cmd.div_start, cmd.div_step, cmd.advance, cmd.load_out}), "overlapping commands")
  `TDPT_ASSERT_IMP(a_no_overwrite, cmd.load_out, (!out_valid || out_ready), "pending result overwritten")

endmodule

// ----- sim/prime_verdict_checker.sv -----
// ----------------------------------------------------------------------------
// prime_verdict_checker
// Watches both channels of the prime tester. Each accepted request queues
// its predicted verdict, and each accepted result is compared with the
// oldest verdict in the queue.
// ----------------------------------------------------------------------------
module prime_verdict_checker import tdpt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_is_prime,
  output int                 verdicts_pending,
  output int                 mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic expected_verdicts[$];

  // Trial division, stopping once the divisor squared passes the value.
  function automatic logic prime_verdict(logic [WIDTH-1:0] candidate);
    int unsigned n;
    int unsigned d;
    n = 32'(candidate);
    if (n < 2) return 1'b0;
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_verdicts.push_back(prime_verdict(in_value[WIDTH-1:0]));
      end
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected result: is_prime=%0b with no request waiting", out_is_prime);
          mismatch_count++;
        end else if (out_is_prime !== expected_verdicts[0]) begin
          $error("is_prime mismatch: expected %0b, actual %0b",
                 expected_verdicts[0], out_is_prime);
          mismatch_count++;
          void'(expected_verdicts.pop_front());
        end else begin
          void'(expected_verdicts.pop_front());
        end
      end
      verdicts_pending <= expected_verdicts.size();
    end
  end

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Top of the prime tester bench. Drives directed boundary values, then
// random requests mixing uniform, small, top-range prime, square and
// two-factor product values, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb import tdpt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [VALUE_W-1:0] in_value;
  logic               out_valid;
  logic               out_ready;
  logic               out_is_prime;
  int                 verdicts_pending;
  int                 mismatch_count;
  bit                 send_calm;
  bit                 recv_calm;

  localparam int NUM_RANDOM = 76;

  // Boundaries, small primes and squares, top-of-range primes, bit patterns.
  localparam logic [15:0] DIRECTED[24] = '{
    16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd9, 16'd25, 16'd49,
    16'd121, 16'd65535, 16'd65534, 16'd65521, 16'd65519, 16'd32749,
    16'd32768, 16'd63001, 16'd60491, 16'd65025, 16'd21845, 16'd43690,
    16'd32767, 16'd65280
  };

  localparam logic [15:0] TOP_PRIMES[8] = '{
    16'd65521, 16'd65519, 16'd65497, 16'd65479, 16'd65449, 16'd65447,
    16'd32749, 16'd40009
  };

  trial_division_prime_test dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_is_prime (out_is_prime)
  );

  prime_verdict_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_is_prime     (out_is_prime),
    .verdicts_pending (verdicts_pending),
    .mismatch_count   (mismatch_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic send_request(input logic [VALUE_W-1:0] value);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (verdicts_pending != 0);
  endtask

  // Result side: random stall before each result, calm stretches between.
  initial begin
    int stall;
    int taken;
    taken = 0;
    out_ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (taken % 16 == 0) recv_calm = ($urandom_range(0, 3) == 0);
      stall = recv_calm ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin
    logic [VALUE_W-1:0] value;
    int unsigned factor_a;
    int unsigned factor_b;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_value <= '0;
    send_calm = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) send_request(DIRECTED[i]);
    // hold off until every verdict so far is back
    drain_results();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 20 == 0) send_calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2: value = VALUE_W'($urandom_range(0, 65535));
        3, 4:    value = VALUE_W'($urandom_range(0, 300));
        5, 6:    value = TOP_PRIMES[3'($urandom_range(0, 7))];
        7: begin
          // squares hit the divisor-squared-equals-value boundary
          factor_a = $urandom_range(2, 255);
          value = VALUE_W'(factor_a * factor_a);
        end
        default: begin
          factor_a = $urandom_range(2, 255);
          factor_b = $urandom_range(2, 65535 / factor_a);
          value = VALUE_W'(factor_a * factor_b);
        end
      endcase
      send_request(value);
      if (i == NUM_RANDOM / 2) drain_results();
    end

    drain_results();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Sized for every request being a top-range prime with maximal gaps.
  initial begin
    #30_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
